// ===== design/lstm_cu_pkg.sv =====
// lstm_cu_pkg: widths, fixed-point helpers and the sigmoid table for the lstm cell update
// depends on nothing; imported by lstm_cell_elementwise_update
`default_nettype none

package lstm_cu_pkg;

    // data format
    localparam int DATA_W      = 16;
    localparam int FRAC_BITS   = 11;
    localparam int LUT_ENTRIES = 256;
    localparam int LUT_BITS    = $clog2(LUT_ENTRIES);
    localparam int SIG_W       = FRAC_BITS + 1;
    localparam int TANH_W      = FRAC_BITS + 2;
    localparam int GATE_W      = DATA_W + 6;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ACC_W       = 40;
    localparam int ADDR_W      = 3;

    // register map
    localparam int REG_USE_PEEPHOLE = 0;

    localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0]  SAT_MAX  = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0]  SAT_MIN  = -ACC_W'(32768);
    localparam logic signed [GATE_W-1:0] SIG_LO   = -GATE_W'(8 << FRAC_BITS);
    localparam logic signed [GATE_W-1:0] SIG_HI   = GATE_W'((8 << FRAC_BITS) - 1);
    localparam logic [63:0]              Q30_ONE  = 64'd1 << 30;

    typedef logic [LUT_ENTRIES-1:0][SIG_W-1:0] t_sig_lut;

    // shift-subtract divide, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-t in Q30 by a short series and repeated squaring
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        y    = t >> 8;
        term = Q30_ONE;
        sum  = Q30_ONE;
        for (int n = 1; n <= 5; n++) begin
            term = (term * y) >> 30;
            case (n)
                2:       term = term / 2;
                3:       term = term / 3;
                4:       term = term / 4;
                5:       term = term / 5;
                default: term = term;
            endcase
            if ((n & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int k = 0; k < 8; k++) begin
            sum = (sum * sum) >> 30;
        end
        return sum;
    endfunction

    // sigmoid at each bin center, rounded to FRAC_BITS
    function automatic t_sig_lut build_sig_lut();
        logic signed [63:0] x;
        logic [63:0]        t;
        logic [63:0]        e;
        logic [63:0]        pos;
        logic [63:0]        s;
        t_sig_lut           lut;
        for (int k = 0; k < LUT_ENTRIES; k++) begin
            x   = $signed((64'(2 * k + 1) << 33) / LUT_ENTRIES) - (64'sd1 <<< 33);
            t   = (x < 0) ? 64'(-x) : 64'(x);
            e   = exp_neg_q30(t);
            pos = udiv64(64'd1 << 60, Q30_ONE + e);
            s   = (x >= 0) ? pos : Q30_ONE - pos;
            s   = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            lut[k] = s[SIG_W-1:0];
        end
        return lut;
    endfunction

    localparam t_sig_lut SIG_LUT = build_sig_lut();

    // clamp to [-8, 8) and read the table
    function automatic logic [SIG_W-1:0] sig_lookup(input logic signed [GATE_W-1:0] x);
        logic [FRAC_BITS+3:0] off;
        logic [LUT_BITS-1:0]  idx;
        off = x[FRAC_BITS+3:0] ^ {1'b1, {(FRAC_BITS + 3){1'b0}}};
        if (x < SIG_LO) begin
            idx = '0;
        end else if (x > SIG_HI) begin
            idx = '1;
        end else begin
            idx = off[FRAC_BITS+3 -: LUT_BITS];
        end
        return SIG_LUT[idx];
    endfunction

    // tanh(x) = 2*sigmoid(2x) - 1, argument already doubled
    function automatic logic signed [TANH_W-1:0] tanh_lookup(
        input logic signed [DATA_W:0] x2
    );
        logic [SIG_W-1:0]  s;
        logic [TANH_W:0]   t;
        s = sig_lookup(GATE_W'(x2));
        t = {1'b0, s, 1'b0} - (TANH_W + 1)'(1 << FRAC_BITS);
        return $signed(t[TANH_W-1:0]);
    endfunction

    // round half up and drop the fraction bits of a product
    function automatic logic signed [ACC_W-1:0] rnd_acc(input logic signed [ACC_W-1:0] v);
        return (v + RND_HALF) >>> FRAC_BITS;
    endfunction

endpackage

`default_nettype wire

// ===== design/lstm_cell_elementwise_update.sv =====
// lstm cell elementwise update with peephole terms, one hidden unit per request
// an accepted input request passes through the stage registers to its result on the output register
// throughput: one request per cycle while i_out_stall is low; each stage holds only while its successor is full
// the chain is set by the dependent multiply steps (peephole, cell, output peephole, hidden)
// reset clears the stage valid bits and use_peephole; the sigmoid table is constant logic
// depends on lstm_cu_pkg
`default_nettype none

module lstm_cell_elementwise_update
    import lstm_cu_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // configuration port
    input  wire                      psel,
    input  wire                      penable,
    input  wire                      pwrite,
    input  wire  [ADDR_W-1:0]        paddr,
    input  wire  [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // input channel
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  signed [DATA_W-1:0] i_gate_input_pre,
    input  wire  signed [DATA_W-1:0] i_gate_output_pre,
    input  wire  signed [DATA_W-1:0] i_gate_forget_pre,
    input  wire  signed [DATA_W-1:0] i_candidate_pre,
    input  wire  signed [DATA_W-1:0] i_cell_prev,
    input  wire  signed [DATA_W-1:0] i_hidden_prev,
    input  wire  signed [DATA_W-1:0] i_peep_input_weight,
    input  wire  signed [DATA_W-1:0] i_peep_output_weight,
    input  wire  signed [DATA_W-1:0] i_peep_forget_weight,
    input  wire                      i_step_active,
    // output channel
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output logic signed [DATA_W-1:0] o_cell_new,
    output logic signed [DATA_W-1:0] o_hidden_new,
    output logic signed [DATA_W-1:0] o_seq_output,
    output logic                     o_cell_saturated
);

    localparam int NUM_ST = 8;

    logic              r_use_peephole;
    logic [NUM_ST-1:0] r_vld;
    logic [NUM_ST-1:0] en;
    logic              cfg_wr;

    // stage 1: peephole products
    logic signed [PROD_W-1:0] r1_prod_i, r1_prod_f;
    logic signed [DATA_W-1:0] r1_gi, r1_gf, r1_gc, r1_go, r1_po, r1_cp, r1_hp;
    logic                     r1_act;
    // stage 2: input, forget and candidate activations
    logic [SIG_W-1:0]         r2_it, r2_ft, n2_it, n2_ft;
    logic signed [TANH_W-1:0] r2_gt, n2_gt;
    logic signed [DATA_W-1:0] r2_go, r2_po, r2_cp, r2_hp;
    logic                     r2_act;
    logic signed [GATE_W-1:0] n2_gi, n2_gf;
    // stage 3: cell products
    logic signed [DATA_W+TANH_W-1:0] r3_pfc, n3_pfc;
    logic signed [2*TANH_W-1:0]      r3_pig, n3_pig;
    logic signed [DATA_W-1:0]        r3_go, r3_po, r3_cp, r3_hp;
    logic                            r3_act;
    // stage 4: new cell, saturated
    logic signed [DATA_W-1:0] r4_cn, n4_cn, r4_go, r4_po, r4_hp;
    logic                     r4_sat, n4_sat, r4_act;
    logic signed [ACC_W-1:0]  n4_sum;
    // stage 5: output peephole product and tanh of new cell
    logic signed [PROD_W-1:0] r5_prod_o;
    logic signed [TANH_W-1:0] r5_tcn;
    logic signed [DATA_W-1:0] r5_cn, r5_go, r5_hp;
    logic                     r5_sat, r5_act;
    // stage 6: output gate
    logic [SIG_W-1:0]         r6_ot, n6_ot;
    logic signed [GATE_W-1:0] n6_go;
    logic signed [TANH_W-1:0] r6_tcn;
    logic signed [DATA_W-1:0] r6_cn, r6_hp;
    logic                     r6_sat, r6_act;
    // stage 7: hidden product
    logic signed [2*TANH_W-1:0] r7_ph;
    logic signed [DATA_W-1:0]   r7_cn, r7_hp;
    logic                       r7_sat, r7_act;
    // stage 8: output register
    logic signed [ACC_W-1:0]  n8_hid;
    logic                     r8_act;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_peephole <= 1'b0;
        end else if (cfg_wr && (paddr[2] == 1'(REG_USE_PEEPHOLE))) begin
            r_use_peephole <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == 1'(REG_USE_PEEPHOLE)) begin
            prdata[0] = r_use_peephole;
        end
    end

    // stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        en[NUM_ST-1] = !r_vld[NUM_ST-1] || !i_out_stall;
        for (int k = NUM_ST - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_stall  = !en[0];
    assign o_out_valid = r_vld[NUM_ST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_ST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_prod_i <= i_peep_input_weight * i_cell_prev;
            r1_prod_f <= i_peep_forget_weight * i_cell_prev;
            r1_gi     <= i_gate_input_pre;
            r1_gf     <= i_gate_forget_pre;
            r1_gc     <= i_candidate_pre;
            r1_go     <= i_gate_output_pre;
            r1_po     <= i_peep_output_weight;
            r1_cp     <= i_cell_prev;
            r1_hp     <= i_hidden_prev;
            r1_act    <= i_step_active;
        end
    end

    // stage 2: gate sums and table reads
    always_comb begin
        n2_gi = GATE_W'(r1_gi);
        n2_gf = GATE_W'(r1_gf);
        if (r_use_peephole) begin
            n2_gi = n2_gi + GATE_W'(rnd_acc(ACC_W'(r1_prod_i)));
            n2_gf = n2_gf + GATE_W'(rnd_acc(ACC_W'(r1_prod_f)));
        end
        n2_it = sig_lookup(n2_gi);
        n2_ft = sig_lookup(n2_gf);
        n2_gt = tanh_lookup((DATA_W + 1)'(r1_gc) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_it  <= n2_it;
            r2_ft  <= n2_ft;
            r2_gt  <= n2_gt;
            r2_go  <= r1_go;
            r2_po  <= r1_po;
            r2_cp  <= r1_cp;
            r2_hp  <= r1_hp;
            r2_act <= r1_act;
        end
    end

    // stage 3: f*c and i*g
    always_comb begin
        n3_pfc = $signed({1'b0, r2_ft}) * r2_cp;
        n3_pig = $signed({1'b0, r2_it}) * r2_gt;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_pfc <= n3_pfc;
            r3_pig <= n3_pig;
            r3_go  <= r2_go;
            r3_po  <= r2_po;
            r3_cp  <= r2_cp;
            r3_hp  <= r2_hp;
            r3_act <= r2_act;
        end
    end

    // stage 4: round, saturate; an inactive step keeps the previous cell
    always_comb begin
        n4_sum = rnd_acc(ACC_W'(r3_pfc) + ACC_W'(r3_pig));
        n4_sat = 1'b0;
        if (n4_sum > SAT_MAX) begin
            n4_cn  = SAT_MAX[DATA_W-1:0];
            n4_sat = 1'b1;
        end else if (n4_sum < SAT_MIN) begin
            n4_cn  = SAT_MIN[DATA_W-1:0];
            n4_sat = 1'b1;
        end else begin
            n4_cn = n4_sum[DATA_W-1:0];
        end
        if (!r3_act) begin
            n4_cn  = r3_cp;
            n4_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_cn  <= n4_cn;
            r4_sat <= n4_sat;
            r4_go  <= r3_go;
            r4_po  <= r3_po;
            r4_hp  <= r3_hp;
            r4_act <= r3_act;
        end
    end

    // stage 5
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_prod_o <= r4_po * r4_cn;
            r5_tcn    <= tanh_lookup((DATA_W + 1)'(r4_cn) <<< 1);
            r5_cn     <= r4_cn;
            r5_sat    <= r4_sat;
            r5_go     <= r4_go;
            r5_hp     <= r4_hp;
            r5_act    <= r4_act;
        end
    end

    // stage 6: output gate
    always_comb begin
        n6_go = GATE_W'(r5_go);
        if (r_use_peephole) begin
            n6_go = n6_go + GATE_W'(rnd_acc(ACC_W'(r5_prod_o)));
        end
        n6_ot = sig_lookup(n6_go);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r6_ot  <= n6_ot;
            r6_tcn <= r5_tcn;
            r6_cn  <= r5_cn;
            r6_sat <= r5_sat;
            r6_hp  <= r5_hp;
            r6_act <= r5_act;
        end
    end

    // stage 7
    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r7_ph  <= $signed({1'b0, r6_ot}) * r6_tcn;
            r7_cn  <= r6_cn;
            r7_sat <= r6_sat;
            r7_hp  <= r6_hp;
            r7_act <= r6_act;
        end
    end

    // stage 8: hidden value, pass-through for an inactive step
    assign n8_hid = rnd_acc(ACC_W'(r7_ph));

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            o_cell_new       <= r7_cn;
            o_cell_saturated <= r7_sat;
            o_hidden_new     <= r7_act ? n8_hid[DATA_W-1:0] : r7_hp;
            o_seq_output     <= r7_act ? n8_hid[DATA_W-1:0] : '0;
            r8_act           <= r7_act;
        end
    end

    // checks
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld))
        else $error("input stalled while a stage is empty");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] && en[4] |=> r_vld[4])
        else $error("request lost between cell and tanh stages");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cell_saturated |->
            (o_cell_new == 16'sh7fff) || (o_cell_new == 16'sh8000))
        else $error("saturation flag without clipped cell");

    a_seq_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r8_act |-> (o_seq_output == o_hidden_new))
        else $error("sequence output differs from hidden on an active step");

endmodule

`default_nettype wire
